// File: design/bmu_pkg.sv
// ----------------------------------------------------------------------------
// Background model update package
// Shared widths, register indexes and the record that travels down the
// divider pipeline.
// ----------------------------------------------------------------------------
package bmu_pkg;

    localparam int LEVEL_W    = 8;
    localparam int RATE_W     = 7;
    localparam int DIV_STAGES = LEVEL_W;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] REG_BACKGROUND_RATE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FOREGROUND_RATE = 1'b1;

    // One pixel in flight. The work field starts as the dividend and is
    // shifted left one bit a stage, taking in quotient bits from the right.
    typedef struct packed {
        logic [LEVEL_W-1:0] rem;
        logic [LEVEL_W-1:0] work;
        logic [LEVEL_W-1:0] divisor;
        logic [LEVEL_W-1:0] base;
        logic               sub;
    } div_data_t;

endpackage

// File: design/background_model_update.sv
// ----------------------------------------------------------------------------
// Background model update
// Selective running-average update of a per-pixel background estimate.
// ----------------------------------------------------------------------------
// The block takes one pixel request per clock while the output side does
// not stall, and returns one updated background level per request, in
// order, from the output register. In the divider the absolute difference
// of the two levels is divided by the selected rate (or twice it, for a
// brighter pixel) one quotient bit per pipeline stage, which gives eight
// division stages between a preparation stage and the output register, ten
// register stages in all. Every stage holds its own valid bit and stalls
// only when full and blocked downstream, so bubbles are squeezed out and a
// stall loses nothing.
// The rate registers are sampled when a pixel enters the preparation stage;
// they are meant to be written only while no pixel is in flight. A rate of
// zero behaves as a rate of one.
module background_model_update (
    input  logic                          aclk,
    input  logic                          aresetn,
    // s_tdata, from bit 0: fg_mask[7:0], current_level[7:0],
    // background_level[7:0]
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [3*bmu_pkg::LEVEL_W-1:0] s_tdata,
    // m_tdata, from bit 0: new_background[7:0]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [bmu_pkg::LEVEL_W-1:0]   m_tdata,
    input  logic                          cfg_wr_en,
    input  logic [bmu_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bmu_pkg::RATE_W-1:0]    cfg_wdata
);

    localparam int NS = bmu_pkg::DIV_STAGES;
    localparam int LW = bmu_pkg::LEVEL_W;

    // Configuration registers.
    logic [bmu_pkg::RATE_W-1:0] bg_rate_reg;
    logic [bmu_pkg::RATE_W-1:0] fg_rate_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bg_rate_reg <= bmu_pkg::RATE_W'(8);
            fg_rate_reg <= bmu_pkg::RATE_W'(32);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                bmu_pkg::REG_BACKGROUND_RATE: bg_rate_reg <= cfg_wdata;
                bmu_pkg::REG_FOREGROUND_RATE: fg_rate_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Pipeline links: index 0 is the preparation stage, index k the output
    // of division step k. stg_ready[k] says the consumer of index k can take it.
    logic               stg_valid [0:NS];
    bmu_pkg::div_data_t stg_data  [0:NS];
    logic               stg_ready [0:NS];

    // Preparation stage: pick the rate and direction, form the difference.
    logic [LW-1:0]              mask_in;
    logic [LW-1:0]              cur_in;
    logic [LW-1:0]              bg_in;
    logic [bmu_pkg::RATE_W-1:0] rate_sel;
    logic [bmu_pkg::RATE_W-1:0] rate_eff;
    logic                       is_bg;
    logic                       brighter;
    logic                       darker;
    bmu_pkg::div_data_t         prep_next;
    logic                       prep_valid_reg;
    bmu_pkg::div_data_t         prep_data_reg;

    always_comb begin
        mask_in  = s_tdata[LW-1:0];
        cur_in   = s_tdata[2*LW-1:LW];
        bg_in    = s_tdata[3*LW-1:2*LW];
        is_bg    = (mask_in == '0);
        brighter = cur_in > bg_in;
        darker   = cur_in < bg_in;
        rate_sel = is_bg ? bg_rate_reg : fg_rate_reg;
        rate_eff = (rate_sel == '0) ? bmu_pkg::RATE_W'(1) : rate_sel;
        prep_next.rem     = '0;
        prep_next.work    = brighter ? (cur_in - bg_in) : (bg_in - cur_in);
        // A brighter pixel divides by twice the rate.
        prep_next.divisor = brighter ? {rate_eff, 1'b0} : {1'b0, rate_eff};
        // Background pixels start from the current level and step back toward
        // the old background; foreground pixels start from the old background.
        prep_next.base    = is_bg ? cur_in : bg_in;
        prep_next.sub     = is_bg ? brighter : darker;
    end

    assign s_tready = !prep_valid_reg || stg_ready[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prep_valid_reg <= 1'b0;
        end else if (s_tready) begin
            prep_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            prep_data_reg <= prep_next;
        end
    end

    assign stg_valid[0] = prep_valid_reg;
    assign stg_data[0]  = prep_data_reg;

    // Division steps, one quotient bit each, most significant first.
    for (genvar k = 1; k <= NS; k++) begin : g_div
        bmu_div_stage u_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (stg_valid[k-1]),
            .in_ready  (stg_ready[k-1]),
            .in_data   (stg_data[k-1]),
            .out_valid (stg_valid[k]),
            .out_ready (stg_ready[k]),
            .out_data  (stg_data[k])
        );
    end

    // Output stage: apply the quotient to the base level. The result always
    // lies between the two input levels, so no clamping is needed.
    logic          m_valid_reg;
    logic [LW-1:0] m_data_reg;
    logic [LW-1:0] m_data_next;

    always_comb begin
        m_data_next = stg_data[NS].sub ? (stg_data[NS].base - stg_data[NS].work)
                                       : (stg_data[NS].base + stg_data[NS].work);
    end

    assign stg_ready[NS] = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (stg_ready[NS]) begin
            m_valid_reg <= stg_valid[NS];
        end
    end

    always_ff @(posedge aclk) begin
        if (stg_ready[NS] && stg_valid[NS]) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

`ifndef ASSERT_OFF
    // With the output register empty every stage can move, so input is open.
    a_open_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid_reg |-> s_tready)
        else $error("input stalled while the output register is empty");

    // The effective divisor is never zero.
    a_divisor_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        stg_valid[0] |-> (stg_data[0].divisor != '0))
        else $error("zero divisor entered the divider");

    // A finished division leaves a remainder below its divisor.
    a_rem_below_div: assert property (@(posedge aclk) disable iff (!aresetn)
        stg_valid[NS] |-> (stg_data[NS].rem < stg_data[NS].divisor))
        else $error("division remainder not below divisor");
`endif

endmodule

// File: design/bmu_div_stage.sv
// ----------------------------------------------------------------------------
// Background model update divider stage
// One restoring-division step behind a register, with its own valid bit.
// ----------------------------------------------------------------------------
module bmu_div_stage (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  bmu_pkg::div_data_t in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output bmu_pkg::div_data_t out_data
);

    logic               valid_reg;
    bmu_pkg::div_data_t data_reg;
    bmu_pkg::div_data_t data_next;
    logic [bmu_pkg::LEVEL_W:0] rem_shift;
    logic [bmu_pkg::LEVEL_W:0] trial;
    logic                      fits;

    always_comb begin
        rem_shift = {in_data.rem, in_data.work[bmu_pkg::LEVEL_W-1]};
        trial     = rem_shift - {1'b0, in_data.divisor};
        // No borrow out of the trial subtraction means the divisor fits.
        fits      = !trial[bmu_pkg::LEVEL_W];
        data_next = in_data;
        data_next.rem  = fits ? trial[bmu_pkg::LEVEL_W-1:0]
                              : rem_shift[bmu_pkg::LEVEL_W-1:0];
        data_next.work = {in_data.work[bmu_pkg::LEVEL_W-2:0], fits};
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule
